/* src/mbrs_pkg.sv */
`default_nettype none

package mbrs_pkg;

  // storage sizes
  localparam int RX_DEPTH      = 256;
  localparam int TX_DEPTH      = 256;
  localparam int REG_COUNT     = 256;
  localparam int READ_QTY_MAX  = 125;
  localparam int WRITE_QTY_MAX = 123;

  localparam int RX_AW  = $clog2(RX_DEPTH);
  localparam int RX_CW  = $clog2(RX_DEPTH + 1);
  localparam int TX_AW  = $clog2(TX_DEPTH);
  localparam int TX_CW  = $clog2(TX_DEPTH + 1);
  localparam int REG_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int QTY_MAX = (READ_QTY_MAX > WRITE_QTY_MAX) ? READ_QTY_MAX : WRITE_QTY_MAX;
  localparam int QTY_W  = $clog2(QTY_MAX + 1);
  localparam int NEED_W = (RX_CW > 9) ? RX_CW : 9;

  // function codes and exception codes
  localparam logic [7:0] FC_RD_HOLD  = 8'h03;
  localparam logic [7:0] FC_RD_INPUT = 8'h04;
  localparam logic [7:0] FC_WR_ONE   = 8'h06;
  localparam logic [7:0] FC_WR_MANY  = 8'h10;
  localparam logic [7:0] EXC_FLAG    = 8'h80;
  localparam logic [1:0] EXC_NONE    = 2'd0;
  localparam logic [1:0] EXC_FUNC    = 2'd1;
  localparam logic [1:0] EXC_ADDR    = 2'd2;
  localparam logic [1:0] EXC_VALUE   = 2'd3;

  // frame shape
  localparam int FIXED_LEN   = 8;
  localparam int MANY_OVH    = 9;
  localparam int MANY_HDR    = 7;
  localparam int READ_OVH    = 5;
  localparam int MIN_FRAME   = 4;

  // actions
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_FETCH = 2'd2;
  localparam logic [1:0] ACT_POLL  = 2'd3;

  // config register indexes
  localparam logic CFG_SLAVE_ADDR = 1'b0;
  localparam logic CFG_SILENCE    = 1'b1;

  // statistics slots
  localparam int ST_FRAMES = 0;
  localparam int ST_CRC    = 1;
  localparam int ST_DISC   = 2;
  localparam int ST_ADDR   = 3;
  localparam int ST_RESP   = 4;
  localparam int ST_EXC    = 5;
  localparam int ST_NUM    = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [4:0] {
    S_IDLE, S_LOOP, S_HDR, S_HDRW, S_EVAL, S_JUDGE, S_CRD, S_CWT, S_CHK,
    S_EXEC, S_WRD, S_WHI, S_WLO, S_TXH, S_BRD, S_BHI, S_BLO, S_SEAL0,
    S_SEAL1, S_ADV, S_FETCH, S_REPORT
  } mbrs_state_e;

  typedef enum logic [1:0] {
    K_READ, K_WONE, K_WMANY, K_EXC
  } mbrs_kind_e;

  typedef struct packed {
    logic        response_ready;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        tx_last;
    logic [8:0]  pending_count;
    logic [15:0] frames_ok;
    logic [15:0] crc_errors;
    logic [15:0] discarded;
    logic [15:0] addr_mismatches;
    logic [15:0] responses;
    logic [15:0] exceptions;
  } mbrs_res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // ring position of entry idx behind the head
  function automatic logic [RX_AW-1:0] rx_wrap(input logic [RX_AW-1:0] head,
                                               input logic [RX_CW-1:0] idx);
    logic [RX_CW:0] s;
    s = (RX_CW+1)'(head) + (RX_CW+1)'(idx);
    if (s >= (RX_CW+1)'(RX_DEPTH)) begin
      s = s - (RX_CW+1)'(RX_DEPTH);
    end
    return RX_AW'(s);
  endfunction

endpackage

`default_nettype wire

/* src/mbrs_ram.sv */
`default_nettype none

module mbrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/mbrs_regbank.sv */
`default_nettype none

module mbrs_regbank (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       we_i,
  input  wire logic [mbrs_pkg::REG_AW-1:0] waddr_i,
  input  wire logic [15:0]                wdata_i,
  input  wire logic                       re_i,
  input  wire logic [mbrs_pkg::REG_AW-1:0] raddr_i,
  output logic      [15:0]                rdata_o
);
  import mbrs_pkg::*;

  logic [REG_COUNT-1:0] valid_q;
  logic                 rd_valid_q;
  logic [15:0]          ram_rdata;

  mbrs_ram #(.Width(16), .Depth(REG_COUNT)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // never-written registers read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_valid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_valid_q ? ram_rdata : 16'h0000;

endmodule

`default_nettype wire

/* src/mbrs_engine.sv */
`default_nettype none

module mbrs_engine (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [1:0]          action_i,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic [7:0]          slave_addr_i,
  input  wire logic [15:0]         silence_ms_i,
  output logic                     ready_o,
  output logic                     res_valid_o,
  input  wire logic                res_take_i,
  output mbrs_pkg::mbrs_res_t      res_o
);
  import mbrs_pkg::*;

  mbrs_state_e state_q, state_d;
  mbrs_kind_e  kind_q, kind_d;

  logic [RX_CW-1:0] count_q, count_d;
  logic [RX_AW-1:0] head_q, head_d;
  logic [TX_CW-1:0] resp_len_q, resp_len_d;
  logic [TX_CW-1:0] pos_q, pos_d;
  logic [15:0]      idle_q, idle_d;
  logic [RX_CW-1:0] prev_q, prev_d;
  logic             silent_q, silent_d;
  logic [15:0]      stat_q [ST_NUM];
  logic [15:0]      stat_d [ST_NUM];

  logic [7:0]       hdr_q [7];
  logic [7:0]       hdr_d [7];
  logic [2:0]       hidx_q, hidx_d;
  logic [RX_CW-1:0] jlen_q, jlen_d;
  logic [RX_CW-1:0] ci_q, ci_d;
  logic [RX_CW-1:0] adv_q, adv_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       wlo_q, wlo_d;
  logic [7:0]       whi_q, whi_d;
  logic [7:0]       th_q [8];
  logic [7:0]       th_d [8];
  logic [3:0]       thn_q, thn_d;
  logic [TX_AW-1:0] ti_q, ti_d;
  logic [15:0]      tcrc_q, tcrc_d;
  logic [15:0]      qa_q, qa_d;
  logic [QTY_W-1:0] qn_q, qn_d;
  logic [QTY_W-1:0] bi_q, bi_d;
  logic [7:0]       wrhi_q, wrhi_d;
  logic [7:0]       txb_q, txb_d;
  logic             txv_q, txv_d;
  logic             txl_q, txl_d;

  // memory ports
  logic             rx_we, rx_re;
  logic [RX_AW-1:0] rx_waddr, rx_raddr;
  logic [7:0]       rx_wdata, rx_rdata;
  logic             tx_we, tx_re;
  logic [TX_AW-1:0] tx_waddr, tx_raddr;
  logic [7:0]       tx_wdata, tx_rdata;
  logic              bk_we, bk_re;
  logic [REG_AW-1:0] bk_waddr, bk_raddr;
  logic [15:0]       bk_wdata, bk_rdata;

  mbrs_ram #(.Width(8), .Depth(RX_DEPTH)) u_rx_ram (
    .clk_i (clk_i), .we_i (rx_we), .waddr_i (rx_waddr), .wdata_i (rx_wdata),
    .re_i (rx_re), .raddr_i (rx_raddr), .rdata_o (rx_rdata)
  );

  mbrs_ram #(.Width(8), .Depth(TX_DEPTH)) u_tx_ram (
    .clk_i (clk_i), .we_i (tx_we), .waddr_i (tx_waddr), .wdata_i (tx_wdata),
    .re_i (tx_re), .raddr_i (tx_raddr), .rdata_o (tx_rdata)
  );

  mbrs_regbank u_bank (
    .clk_i (clk_i), .rst_ni (rst_ni), .we_i (bk_we), .waddr_i (bk_waddr),
    .wdata_i (bk_wdata), .re_i (bk_re), .raddr_i (bk_raddr), .rdata_o (bk_rdata)
  );

  // header decode
  logic [7:0]        h0, fc;
  logic [15:0]       word_a, word_q;
  logic              fc_fixed, cons, reply, n_ge2, n_ge7, hcs, own;
  logic [NEED_W-1:0] need9, need_v;
  logic [15:0]       idle_n;
  logic [1:0]        exc_v;

  always_comb begin
    h0       = hdr_q[0];
    fc       = hdr_q[1];
    word_a   = {hdr_q[2], hdr_q[3]};
    word_q   = {hdr_q[4], hdr_q[5]};
    fc_fixed = (fc == FC_RD_HOLD) || (fc == FC_RD_INPUT) || (fc == FC_WR_ONE);
    cons     = ({9'd0, hdr_q[6]} == {word_q, 1'b0});
    reply    = (h0 != 8'h00);
    n_ge2    = (count_q >= RX_CW'(2));
    n_ge7    = (count_q >= RX_CW'(MANY_HDR));
    need9    = NEED_W'(hdr_q[6]) + NEED_W'(MANY_OVH);

    if (!n_ge2) begin
      need_v = '0;
    end else if (fc_fixed) begin
      need_v = NEED_W'(FIXED_LEN);
    end else if (fc == FC_WR_MANY) begin
      need_v = (n_ge7 && cons) ? need9 : '0;
    end else begin
      need_v = '0;
    end

    if (!n_ge2) begin
      hcs = 1'b1;
    end else if (fc == FC_WR_MANY) begin
      if ((h0 != slave_addr_i) && (h0 != 8'h00)) begin
        hcs = 1'b0;
      end else begin
        hcs = n_ge7 ? cons : 1'b1;
      end
    end else if (fc_fixed) begin
      hcs = (h0 == slave_addr_i) || (h0 == 8'h00);
    end else begin
      hcs = (h0 == slave_addr_i);
    end

    if (h0 != slave_addr_i) begin
      own = 1'b0;
    end else if (fc_fixed) begin
      own = (jlen_q == RX_CW'(FIXED_LEN));
    end else if (fc == FC_WR_MANY) begin
      own = (jlen_q >= RX_CW'(MANY_HDR)) && cons && (NEED_W'(jlen_q) == need9);
    end else begin
      own = 1'b0;
    end
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    count_d    = count_q;
    head_d     = head_q;
    resp_len_d = resp_len_q;
    pos_d      = pos_q;
    idle_d     = idle_q;
    prev_d     = prev_q;
    silent_d   = silent_q;
    stat_d     = stat_q;
    hdr_d      = hdr_q;
    hidx_d     = hidx_q;
    jlen_d     = jlen_q;
    ci_d       = ci_q;
    adv_d      = adv_q;
    crc_d      = crc_q;
    wlo_d      = wlo_q;
    whi_d      = whi_q;
    th_d       = th_q;
    thn_d      = thn_q;
    ti_d       = ti_q;
    tcrc_d     = tcrc_q;
    qa_d       = qa_q;
    qn_d       = qn_q;
    bi_d       = bi_q;
    wrhi_d     = wrhi_q;
    txb_d      = txb_q;
    txv_d      = txv_q;
    txl_d      = txl_q;
    idle_n     = '0;
    exc_v      = EXC_NONE;

    rx_we    = 1'b0;
    rx_waddr = rx_wrap(head_q, count_q);
    rx_wdata = rx_byte_i;
    rx_re    = 1'b0;
    rx_raddr = rx_wrap(head_q, RX_CW'(hidx_q));
    tx_we    = 1'b0;
    tx_waddr = ti_q;
    tx_wdata = th_q[ti_q[2:0]];
    tx_re    = 1'b0;
    tx_raddr = pos_q[TX_AW-1:0];
    bk_we    = 1'b0;
    bk_waddr = REG_AW'(qa_q + 16'(bi_q));
    bk_wdata = {wrhi_q, rx_rdata};
    bk_re    = 1'b0;
    bk_raddr = REG_AW'(qa_q + 16'(bi_q));

    ready_o     = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          txb_d = 8'h00;
          txv_d = 1'b0;
          txl_d = 1'b0;
          unique case (action_i)
            ACT_BYTE, ACT_POLL: begin
              resp_len_d = '0;
              pos_d      = '0;
              if (action_i == ACT_BYTE) begin
                idle_d = '0;
                if (count_q == RX_CW'(RX_DEPTH)) begin
                  stat_d[ST_DISC] = stat_q[ST_DISC] + 16'd1;
                  count_d = '0;
                  head_d  = '0;
                end else begin
                  rx_we   = 1'b1;
                  count_d = count_q + RX_CW'(1);
                end
              end
              state_d = S_LOOP;
            end
            ACT_TICK: begin
              if (count_q == '0) begin
                idle_d  = '0;
                prev_d  = '0;
                state_d = S_REPORT;
              end else begin
                if (count_q == prev_q) begin
                  idle_n = idle_q + 16'd1;
                  prev_d = prev_q;
                end else begin
                  idle_n = '0;
                  prev_d = count_q;
                end
                if (idle_n >= silence_ms_i) begin
                  idle_d   = '0;
                  prev_d   = '0;
                  silent_d = 1'b1;
                  jlen_d   = count_q;
                  hidx_d   = '0;
                  state_d  = S_HDR;
                end else begin
                  idle_d  = idle_n;
                  state_d = S_REPORT;
                end
              end
            end
            default: begin
              if ((pos_q < resp_len_q) && (pos_q < TX_CW'(TX_DEPTH))) begin
                tx_re   = 1'b1;
                state_d = S_FETCH;
              end else begin
                state_d = S_REPORT;
              end
            end
          endcase
        end
      end

      S_LOOP: begin
        if ((resp_len_q != '0) || (count_q == '0)) begin
          state_d = S_REPORT;
        end else begin
          hidx_d  = '0;
          state_d = S_HDR;
        end
      end

      S_HDR: begin
        rx_re   = 1'b1;
        state_d = S_HDRW;
      end

      S_HDRW: begin
        hdr_d[hidx_q] = rx_rdata;
        if ((hidx_q == 3'd6) || ((RX_CW'(hidx_q) + RX_CW'(1)) == count_q)) begin
          state_d = silent_q ? S_JUDGE : S_EVAL;
        end else begin
          hidx_d  = hidx_q + 3'd1;
          state_d = S_HDR;
        end
      end

      S_EVAL: begin
        if (need_v == '0) begin
          if (hcs) begin
            state_d = S_REPORT;
          end else begin
            stat_d[ST_DISC] = stat_q[ST_DISC] + 16'd1;
            adv_d   = RX_CW'(1);
            state_d = S_ADV;
          end
        end else if (need_v > NEED_W'(count_q)) begin
          state_d = S_REPORT;
        end else begin
          jlen_d  = RX_CW'(need_v);
          state_d = S_JUDGE;
        end
      end

      S_JUDGE: begin
        if (jlen_q < RX_CW'(MIN_FRAME)) begin
          stat_d[ST_DISC] = stat_q[ST_DISC] + 16'd1;
          adv_d   = jlen_q;
          state_d = S_ADV;
        end else begin
          crc_d   = CRC_INIT;
          ci_d    = '0;
          state_d = S_CRD;
        end
      end

      S_CRD: begin
        rx_re    = 1'b1;
        rx_raddr = rx_wrap(head_q, ci_q);
        state_d  = S_CWT;
      end

      S_CWT: begin
        if (ci_q < (jlen_q - RX_CW'(2))) begin
          crc_d = crc_byte(crc_q, rx_rdata);
        end
        if (ci_q == (jlen_q - RX_CW'(2))) begin
          wlo_d = rx_rdata;
        end
        if (ci_q == (jlen_q - RX_CW'(1))) begin
          whi_d   = rx_rdata;
          state_d = S_CHK;
        end else begin
          ci_d    = ci_q + RX_CW'(1);
          state_d = S_CRD;
        end
      end

      S_CHK: begin
        if ({whi_q, wlo_q} != crc_q) begin
          if (own) begin
            stat_d[ST_CRC] = stat_q[ST_CRC] + 16'd1;
            adv_d = jlen_q;
          end else begin
            stat_d[ST_DISC] = stat_q[ST_DISC] + 16'd1;
            adv_d = RX_CW'(1);
          end
          state_d = S_ADV;
        end else if ((h0 != slave_addr_i) && (h0 != 8'h00)) begin
          stat_d[ST_ADDR] = stat_q[ST_ADDR] + 16'd1;
          adv_d   = jlen_q;
          state_d = S_ADV;
        end else begin
          stat_d[ST_FRAMES] = stat_q[ST_FRAMES] + 16'd1;
          adv_d   = jlen_q;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        ti_d    = '0;
        tcrc_d  = CRC_INIT;
        qa_d    = word_a;
        qn_d    = QTY_W'(word_q);
        bi_d    = '0;
        state_d = S_ADV;
        if ((fc == FC_RD_HOLD) || (fc == FC_RD_INPUT)) begin
          if (jlen_q != RX_CW'(FIXED_LEN)) begin
            exc_v = EXC_VALUE;
          end else if (reply) begin
            if ((word_q == 16'd0) || (word_q > 16'(READ_QTY_MAX)) ||
                ((18'(READ_OVH) + {1'b0, word_q, 1'b0}) > 18'(TX_DEPTH))) begin
              exc_v = EXC_VALUE;
            end else if (({1'b0, word_a} + {1'b0, word_q}) > 17'(REG_COUNT)) begin
              exc_v = EXC_ADDR;
            end else begin
              th_d[0] = h0;
              th_d[1] = fc;
              th_d[2] = {word_q[6:0], 1'b0};
              thn_d   = 4'd3;
              kind_d  = K_READ;
              state_d = S_TXH;
            end
          end
        end else if (fc == FC_WR_ONE) begin
          if (jlen_q != RX_CW'(FIXED_LEN)) begin
            exc_v = EXC_VALUE;
          end else if (17'(word_a) >= 17'(REG_COUNT)) begin
            exc_v = EXC_ADDR;
          end else begin
            bk_we    = 1'b1;
            bk_waddr = REG_AW'(word_a);
            bk_wdata = word_q;
            if (reply) begin
              th_d[0] = hdr_q[0];
              th_d[1] = hdr_q[1];
              th_d[2] = hdr_q[2];
              th_d[3] = hdr_q[3];
              th_d[4] = hdr_q[4];
              th_d[5] = hdr_q[5];
              th_d[6] = wlo_q;
              th_d[7] = whi_q;
              thn_d   = 4'd8;
              kind_d  = K_WONE;
              state_d = S_TXH;
            end
          end
        end else if (fc == FC_WR_MANY) begin
          if (jlen_q < RX_CW'(MANY_OVH)) begin
            exc_v = EXC_VALUE;
          end else if ((word_q == 16'd0) || (word_q > 16'(WRITE_QTY_MAX)) || !cons ||
                       (NEED_W'(jlen_q) != need9)) begin
            exc_v = EXC_VALUE;
          end else if (({1'b0, word_a} + {1'b0, word_q}) > 17'(REG_COUNT)) begin
            exc_v = EXC_ADDR;
          end else begin
            state_d = S_WRD;
          end
        end else begin
          exc_v = EXC_FUNC;
        end
        if ((exc_v != EXC_NONE) && reply) begin
          th_d[0] = h0;
          th_d[1] = fc | EXC_FLAG;
          th_d[2] = {6'd0, exc_v};
          thn_d   = 4'd3;
          kind_d  = K_EXC;
          state_d = S_TXH;
        end
      end

      S_WRD: begin
        rx_re    = 1'b1;
        rx_raddr = rx_wrap(head_q, RX_CW'({bi_q, 1'b0}) + RX_CW'(MANY_HDR));
        state_d  = S_WHI;
      end

      S_WHI: begin
        wrhi_d   = rx_rdata;
        rx_re    = 1'b1;
        rx_raddr = rx_wrap(head_q, RX_CW'({bi_q, 1'b0}) + RX_CW'(MANY_HDR + 1));
        state_d  = S_WLO;
      end

      S_WLO: begin
        bk_we = 1'b1;
        if ((bi_q + QTY_W'(1)) == qn_q) begin
          if (reply) begin
            th_d[0] = hdr_q[0];
            th_d[1] = hdr_q[1];
            th_d[2] = hdr_q[2];
            th_d[3] = hdr_q[3];
            th_d[4] = hdr_q[4];
            th_d[5] = hdr_q[5];
            thn_d   = 4'd6;
            kind_d  = K_WMANY;
            state_d = S_TXH;
          end else begin
            state_d = S_ADV;
          end
        end else begin
          bi_d    = bi_q + QTY_W'(1);
          state_d = S_WRD;
        end
      end

      S_TXH: begin
        tx_we  = 1'b1;
        tcrc_d = crc_byte(tcrc_q, th_q[ti_q[2:0]]);
        ti_d   = ti_q + TX_AW'(1);
        if ((4'(ti_q) + 4'd1) == thn_q) begin
          unique case (kind_q)
            K_READ: begin
              bi_d    = '0;
              state_d = S_BRD;
            end
            K_WONE: begin
              resp_len_d = TX_CW'(FIXED_LEN);
              pos_d      = '0;
              stat_d[ST_RESP] = stat_q[ST_RESP] + 16'd1;
              state_d    = S_ADV;
            end
            default: begin
              state_d = S_SEAL0;
            end
          endcase
        end
      end

      S_BRD: begin
        bk_re   = 1'b1;
        state_d = S_BHI;
      end

      S_BHI: begin
        tx_we    = 1'b1;
        tx_wdata = bk_rdata[15:8];
        tcrc_d   = crc_byte(tcrc_q, bk_rdata[15:8]);
        ti_d     = ti_q + TX_AW'(1);
        state_d  = S_BLO;
      end

      S_BLO: begin
        tx_we    = 1'b1;
        tx_wdata = bk_rdata[7:0];
        tcrc_d   = crc_byte(tcrc_q, bk_rdata[7:0]);
        ti_d     = ti_q + TX_AW'(1);
        if ((bi_q + QTY_W'(1)) == qn_q) begin
          state_d = S_SEAL0;
        end else begin
          bi_d    = bi_q + QTY_W'(1);
          state_d = S_BRD;
        end
      end

      S_SEAL0: begin
        tx_we    = 1'b1;
        tx_wdata = tcrc_q[7:0];
        ti_d     = ti_q + TX_AW'(1);
        state_d  = S_SEAL1;
      end

      S_SEAL1: begin
        tx_we      = 1'b1;
        tx_wdata   = tcrc_q[15:8];
        resp_len_d = TX_CW'(ti_q) + TX_CW'(1);
        pos_d      = '0;
        stat_d[ST_RESP] = stat_q[ST_RESP] + 16'd1;
        if (kind_q == K_EXC) begin
          stat_d[ST_EXC] = stat_q[ST_EXC] + 16'd1;
        end
        state_d = S_ADV;
      end

      S_ADV: begin
        if (silent_q) begin
          count_d  = '0;
          head_d   = '0;
          silent_d = 1'b0;
          state_d  = S_REPORT;
        end else begin
          if (adv_q >= count_q) begin
            count_d = '0;
            head_d  = '0;
          end else begin
            head_d  = rx_wrap(head_q, adv_q);
            count_d = count_q - adv_q;
          end
          state_d = S_LOOP;
        end
      end

      S_FETCH: begin
        txb_d   = tx_rdata;
        txv_d   = 1'b1;
        txl_d   = ((pos_q + TX_CW'(1)) == resp_len_q);
        pos_d   = pos_q + TX_CW'(1);
        state_d = S_REPORT;
      end

      S_REPORT: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      head_q     <= '0;
      resp_len_q <= '0;
      pos_q      <= '0;
      idle_q     <= '0;
      prev_q     <= '0;
      silent_q   <= 1'b0;
      for (int k = 0; k < ST_NUM; k++) begin
        stat_q[k] <= '0;
      end
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      head_q     <= head_d;
      resp_len_q <= resp_len_d;
      pos_q      <= pos_d;
      idle_q     <= idle_d;
      prev_q     <= prev_d;
      silent_q   <= silent_d;
      stat_q     <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    hdr_q  <= hdr_d;
    hidx_q <= hidx_d;
    jlen_q <= jlen_d;
    ci_q   <= ci_d;
    adv_q  <= adv_d;
    crc_q  <= crc_d;
    wlo_q  <= wlo_d;
    whi_q  <= whi_d;
    th_q   <= th_d;
    thn_q  <= thn_d;
    ti_q   <= ti_d;
    tcrc_q <= tcrc_d;
    qa_q   <= qa_d;
    qn_q   <= qn_d;
    bi_q   <= bi_d;
    wrhi_q <= wrhi_d;
    txb_q  <= txb_d;
    txv_q  <= txv_d;
    txl_q  <= txl_d;
  end

  always_comb begin
    res_o.response_ready  = (resp_len_q != '0);
    res_o.tx_byte         = txb_q;
    res_o.tx_valid        = txv_q;
    res_o.tx_last         = txl_q;
    res_o.pending_count   = 9'(count_q);
    res_o.frames_ok       = stat_q[ST_FRAMES];
    res_o.crc_errors      = stat_q[ST_CRC];
    res_o.discarded       = stat_q[ST_DISC];
    res_o.addr_mismatches = stat_q[ST_ADDR];
    res_o.responses       = stat_q[ST_RESP];
    res_o.exceptions      = stat_q[ST_EXC];
  end

endmodule

`default_nettype wire

/* src/modbus_rtu_slave_framer_top.sv */
// channel  direction  handshake                 payload
// in       sink       in_valid_i / in_stall_o   action_i, rx_byte_i
// out      source     out_valid_o / out_stall_i response_ready_o .. exceptions_o
// cfg      sink       cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// one transaction at a time: a fetch reads at most one reply byte, a plain tick and a poll
// with an empty buffer only report; framing reads up to 7 header bytes, walks the crc over
// the frame bytes of the receive ring, reads or writes each register and writes each
// reply byte
// reset clears counters, pointers and the register bank valid bits at once; no clearing pass
// a stalled result sits in the output register while the next transaction is accepted

`default_nettype none

module modbus_rtu_slave_framer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  rx_byte_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             response_ready_o,
  output logic [7:0]       tx_byte_o,
  output logic             tx_valid_o,
  output logic             tx_last_o,
  output logic [8:0]       pending_count_o,
  output logic [15:0]      frames_ok_o,
  output logic [15:0]      crc_errors_o,
  output logic [15:0]      discarded_o,
  output logic [15:0]      addr_mismatches_o,
  output logic [15:0]      responses_o,
  output logic [15:0]      exceptions_o,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import mbrs_pkg::*;

  logic [7:0]  slave_addr_q;
  logic [15:0] silence_q;
  logic        eng_ready, eng_res_valid, take;
  mbrs_res_t   eng_res;
  logic        out_valid_q, out_valid_d;
  mbrs_res_t   res_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'd1;
      silence_q    <= 16'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SLAVE_ADDR: slave_addr_q <= cfg_data_i[7:0];
        CFG_SILENCE:    silence_q    <= cfg_data_i;
        default:        slave_addr_q <= slave_addr_q;
      endcase
    end
  end

  // sequencer owns the receive ring, transmit store and register bank
  mbrs_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_valid_i && eng_ready),
    .action_i     (action_i),
    .rx_byte_i    (rx_byte_i),
    .slave_addr_i (slave_addr_q),
    .silence_ms_i (silence_q),
    .ready_o      (eng_ready),
    .res_valid_o  (eng_res_valid),
    .res_take_i   (take),
    .res_o        (eng_res)
  );

  assign in_stall_o = !eng_ready;

  // output register, loaded whenever it is empty or being drained
  assign take = eng_res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= eng_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign response_ready_o  = res_q.response_ready;
  assign tx_byte_o         = res_q.tx_byte;
  assign tx_valid_o        = res_q.tx_valid;
  assign tx_last_o         = res_q.tx_last;
  assign pending_count_o   = res_q.pending_count;
  assign frames_ok_o       = res_q.frames_ok;
  assign crc_errors_o      = res_q.crc_errors;
  assign discarded_o       = res_q.discarded;
  assign addr_mismatches_o = res_q.addr_mismatches;
  assign responses_o       = res_q.responses;
  assign exceptions_o      = res_q.exceptions;

endmodule

`default_nettype wire

/* bench/tb_modbus_rtu_slave_framer_top.sv */
`default_nettype none

module tb_modbus_rtu_slave_framer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbrs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ACT_POLL;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        response_ready_o;
  logic [7:0]  tx_byte_o;
  logic        tx_valid_o;
  logic        tx_last_o;
  logic [8:0]  pending_count_o;
  logic [15:0] frames_ok_o, crc_errors_o, discarded_o;
  logic [15:0] addr_mismatches_o, responses_o, exceptions_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_SLAVE_ADDR;
  logic [15:0] cfg_data_i = 16'h0000;

  modbus_rtu_slave_framer_top dut (.*);

  always #4 clk_i = ~clk_i;

  // slave model state
  logic [7:0]  rx_buf [RX_DEPTH];
  logic [7:0]  tx_buf [TX_DEPTH];
  logic [15:0] bank [REG_COUNT];
  logic [15:0] stats [ST_NUM];
  int          rx_n, tx_len, tx_pos, quiet_ticks, last_n;
  int          my_addr, my_silence;

  mbrs_res_t   expected_q [$];
  int          errors, items, n_frames_sent, n_fetched;
  bit          quiet, hold_req;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
    c = c ^ {8'h00, d};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic void bump(int k);
    stats[k] = stats[k] + 16'd1;
  endfunction

  function automatic int word_at(int i);
    return {rx_buf[i], rx_buf[i+1]};
  endfunction

  function automatic bit count_ok();
    return int'(rx_buf[6]) == 2 * word_at(4);
  endfunction

  function automatic void seal(int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) c = crc_step(c, tx_buf[i]);
    tx_buf[n] = c[7:0];
    tx_buf[n+1] = c[15:8];
    tx_len = n + 2;
    tx_pos = 0;
    bump(ST_RESP);
  endfunction

  function automatic int frame_need(int n);
    if (n < 2) return 0;
    case (rx_buf[1])
      FC_RD_HOLD, FC_RD_INPUT, FC_WR_ONE: return FIXED_LEN;
      FC_WR_MANY: begin
        if (n < MANY_HDR || !count_ok()) return 0;
        return int'(rx_buf[6]) + MANY_OVH;
      end
      default: return 0;
    endcase
  endfunction

  // can the bytes at the head still become a request
  function automatic bit head_alive(int n);
    int a, f;
    if (n < 2) return 1'b1;
    a = rx_buf[0];
    f = rx_buf[1];
    if (f == FC_WR_MANY) begin
      if (a != my_addr && a != 0) return 1'b0;
      if (n < MANY_HDR) return 1'b1;
      return count_ok();
    end
    if (f == FC_RD_HOLD || f == FC_RD_INPUT || f == FC_WR_ONE)
      return a == my_addr || a == 0;
    return a == my_addr;
  endfunction

  function automatic bit shaped_for_us(int n);
    if (n < 2 || rx_buf[0] != my_addr) return 1'b0;
    case (rx_buf[1])
      FC_RD_HOLD, FC_RD_INPUT, FC_WR_ONE: return n == FIXED_LEN;
      FC_WR_MANY: begin
        if (n < MANY_HDR) return 1'b0;
        return count_ok() && n == int'(rx_buf[6]) + MANY_OVH;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void exc_reply(int f, int e);
    tx_buf[0] = rx_buf[0];
    tx_buf[1] = 8'(f) | EXC_FLAG;
    tx_buf[2] = 8'(e);
    seal(3);
    bump(ST_EXC);
  endfunction

  function automatic int do_read(int f, bit reply, int len);
    int a, q;
    if (len != FIXED_LEN) return EXC_VALUE;
    if (!reply) return EXC_NONE;
    a = word_at(2);
    q = word_at(4);
    if (q == 0 || q > READ_QTY_MAX) return EXC_VALUE;
    if (READ_OVH + 2 * q > TX_DEPTH) return EXC_VALUE;
    if (a + q > REG_COUNT) return EXC_ADDR;
    for (int i = 0; i < q; i++) begin
      tx_buf[3+2*i] = bank[a+i][15:8];
      tx_buf[4+2*i] = bank[a+i][7:0];
    end
    tx_buf[0] = rx_buf[0];
    tx_buf[1] = 8'(f);
    tx_buf[2] = 8'(2 * q);
    seal(3 + 2 * q);
    return EXC_NONE;
  endfunction

  function automatic int do_write_one(bit reply, int len);
    int a;
    if (len != FIXED_LEN) return EXC_VALUE;
    a = word_at(2);
    if (a >= REG_COUNT) return EXC_ADDR;
    bank[a] = 16'(word_at(4));
    if (reply) begin
      for (int i = 0; i < FIXED_LEN; i++) tx_buf[i] = rx_buf[i];
      tx_len = FIXED_LEN;
      tx_pos = 0;
      bump(ST_RESP);
    end
    return EXC_NONE;
  endfunction

  function automatic int do_write_many(bit reply, int len);
    int a, q;
    if (len < MANY_OVH) return EXC_VALUE;
    a = word_at(2);
    q = word_at(4);
    if (q == 0 || q > WRITE_QTY_MAX || int'(rx_buf[6]) != 2 * q ||
        len != MANY_OVH + int'(rx_buf[6]))
      return EXC_VALUE;
    if (a + q > REG_COUNT) return EXC_ADDR;
    for (int i = 0; i < q; i++) bank[a+i] = 16'(word_at(7 + 2 * i));
    if (reply) begin
      for (int i = 0; i < 6; i++) tx_buf[i] = rx_buf[i];
      seal(6);
    end
    return EXC_NONE;
  endfunction

  function automatic void execute(int len);
    int f, e;
    bit reply;
    f = rx_buf[1];
    reply = rx_buf[0] != 0;
    case (8'(f))
      FC_RD_HOLD, FC_RD_INPUT: e = do_read(f, reply, len);
      FC_WR_ONE:               e = do_write_one(reply, len);
      FC_WR_MANY:              e = do_write_many(reply, len);
      default:                 e = EXC_FUNC;
    endcase
    if (e != EXC_NONE && reply) exc_reply(f, e);
  endfunction

  // judge the first len bytes as one frame, return how far to move on
  function automatic int judge(int len);
    logic [15:0] c;
    if (len < MIN_FRAME) begin
      bump(ST_DISC);
      return len;
    end
    c = 16'hFFFF;
    for (int i = 0; i < len - 2; i++) c = crc_step(c, rx_buf[i]);
    if ({rx_buf[len-1], rx_buf[len-2]} != c) begin
      if (shaped_for_us(len)) begin
        bump(ST_CRC);
        return len;
      end
      bump(ST_DISC);
      return 1;
    end
    if (rx_buf[0] != my_addr && rx_buf[0] != 0) begin
      bump(ST_ADDR);
      return len;
    end
    bump(ST_FRAMES);
    execute(len);
    return len;
  endfunction

  function automatic void pop_front_bytes(int k);
    if (k >= rx_n) rx_n = 0;
    else begin
      for (int i = 0; i < rx_n - k; i++) rx_buf[i] = rx_buf[i+k];
      rx_n -= k;
    end
  endfunction

  function automatic void frame_scan();
    int need;
    while (tx_len == 0 && rx_n > 0) begin
      need = frame_need(rx_n);
      if (need == 0) begin
        if (head_alive(rx_n)) break;
        bump(ST_DISC);
        pop_front_bytes(1);
        continue;
      end
      if (need > rx_n) break;
      pop_front_bytes(judge(need));
    end
  endfunction

  function automatic mbrs_res_t slave_step(logic [1:0] a, logic [7:0] b);
    mbrs_res_t r;
    r = '0;
    if (a == ACT_BYTE || a == ACT_POLL) begin
      tx_len = 0;
      tx_pos = 0;
      if (a == ACT_BYTE) begin
        if (rx_n + 1 > RX_DEPTH) begin
          bump(ST_DISC);
          rx_n = 0;
        end else begin
          rx_buf[rx_n] = b;
          rx_n++;
        end
        quiet_ticks = 0;
      end
      frame_scan();
    end else if (a == ACT_TICK) begin
      if (rx_n == 0) begin
        quiet_ticks = 0;
        last_n = 0;
      end else begin
        if (rx_n == last_n) quiet_ticks = (quiet_ticks + 1) & 16'hFFFF;
        else begin
          quiet_ticks = 0;
          last_n = rx_n;
        end
        if (quiet_ticks >= my_silence) begin
          void'(judge(rx_n));
          rx_n = 0;
          quiet_ticks = 0;
          last_n = 0;
        end
      end
    end else if (tx_pos < tx_len && tx_pos < TX_DEPTH) begin
      r.tx_byte = tx_buf[tx_pos];
      r.tx_valid = 1'b1;
      r.tx_last = (tx_pos + 1 == tx_len);
      tx_pos++;
    end
    r.response_ready = tx_len != 0;
    r.pending_count = 9'(rx_n);
    r.frames_ok = stats[ST_FRAMES];
    r.crc_errors = stats[ST_CRC];
    r.discarded = stats[ST_DISC];
    r.addr_mismatches = stats[ST_ADDR];
    r.responses = stats[ST_RESP];
    r.exceptions = stats[ST_EXC];
    return r;
  endfunction

  // one input transaction; a typed row expects the all-zero reset result
  task automatic put_item(input logic [1:0] a, input logic [7:0] b, input bit typed = 1'b0);
    mbrs_res_t r;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= a;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    r = slave_step(a, b);
    expected_q.push_back(typed ? mbrs_res_t'('0) : r);
    items++;
    if (a == ACT_FETCH && r.tx_valid) n_fetched++;
    @(negedge clk_i);
  endtask

  // register write, only while nothing is in flight
  task automatic write_reg(input logic idx, input int val);
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (20) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 16'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SLAVE_ADDR) my_addr = val & 8'hFF;
    else my_silence = val & 16'hFFFF;
  endtask

  // one request with random content, then fetches, ticks, polls or noise
  task automatic send_request();
    logic [7:0]  fr [$];
    logic [15:0] c;
    int          r, st, fc, ra, q, bc, n;
    fr = {};
    r = $urandom_range(0, 9);
    st = (r < 7) ? my_addr : (r == 7) ? 0 : (r == 8) ? $urandom_range(1, 247) :
         $urandom_range(0, 255);
    r = $urandom_range(0, 9);
    ra = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 255);
    if (r < 3) begin
      fc = $urandom_range(0, 1) ? FC_RD_HOLD : FC_RD_INPUT;
      case ($urandom_range(0, 9))
        0: q = 0;
        1: q = READ_QTY_MAX;
        2: q = READ_QTY_MAX + 1;
        3: q = $urandom_range(0, 65535);
        default: q = $urandom_range(1, 8);
      endcase
      fr = '{8'(st), 8'(fc), 8'(ra >> 8), 8'(ra), 8'(q >> 8), 8'(q)};
    end else if (r < 5) begin
      q = $urandom_range(0, 65535);
      fr = '{8'(st), FC_WR_ONE, 8'(ra >> 8), 8'(ra), 8'(q >> 8), 8'(q)};
    end else if (r < 9) begin
      case ($urandom_range(0, 11))
        0: q = 0;
        1: q = WRITE_QTY_MAX;
        2: q = WRITE_QTY_MAX + 1;
        default: q = $urandom_range(1, 6);
      endcase
      bc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : (2 * q) & 8'hFF;
      fr = '{8'(st), FC_WR_MANY, 8'(ra >> 8), 8'(ra), 8'(q >> 8), 8'(q), 8'(bc)};
      repeat (bc) fr.push_back(8'($urandom_range(0, 255)));
    end else begin
      // random function code, mostly one the slave does not serve
      fr = '{8'(st), 8'($urandom_range(0, 255))};
      repeat (6) fr.push_back(8'($urandom_range(0, 255)));
    end
    c = 16'hFFFF;
    foreach (fr[i]) c = crc_step(c, fr[i]);
    if ($urandom_range(0, 9) == 0) c = c ^ (16'd1 << $urandom_range(0, 15));
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    foreach (fr[i]) put_item(ACT_BYTE, fr[i]);
    n_frames_sent++;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : tx_len + $urandom_range(0, 2);
    repeat (n) put_item(ACT_FETCH, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      n = (my_silence < 8) ? my_silence + $urandom_range(0, 2) : $urandom_range(1, 10);
      repeat (n) put_item(ACT_TICK, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) put_item(ACT_FETCH, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) put_item(ACT_POLL, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) put_item(ACT_BYTE, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input int target);
    while (items < target) send_request();
  endtask

  // result checking
  task automatic check_field(input string nm, input int e, input int a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, nm, e, a);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    mbrs_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction", $realtime);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("response_ready", e.response_ready, response_ready_o);
        check_field("tx_byte", e.tx_byte, tx_byte_o);
        check_field("tx_valid", e.tx_valid, tx_valid_o);
        check_field("tx_last", e.tx_last, tx_last_o);
        check_field("pending_count", e.pending_count, pending_count_o);
        check_field("frames_ok", e.frames_ok, frames_ok_o);
        check_field("crc_errors", e.crc_errors, crc_errors_o);
        check_field("discarded", e.discarded, discarded_o);
        check_field("addr_mismatches", e.addr_mismatches, addr_mismatches_o);
        check_field("responses", e.responses, responses_o);
        check_field("exceptions", e.exceptions, exceptions_o);
      end
    end
  end

  // receiver stalls: random bursts, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
  end

  typedef struct {
    logic [1:0] act;
    logic [7:0] data;
    bit         typed;
  } stim_row_t;

  // reset results, a one-register read and a single write with their replies
  stim_row_t dir_rows [] = '{
    '{ACT_POLL, 8'h00, 1'b1}, '{ACT_FETCH, 8'hFF, 1'b1}, '{ACT_TICK, 8'h00, 1'b1},
    '{ACT_BYTE, 8'h01, 1'b0}, '{ACT_BYTE, 8'h03, 1'b0}, '{ACT_BYTE, 8'h00, 1'b0},
    '{ACT_BYTE, 8'h00, 1'b0}, '{ACT_BYTE, 8'h00, 1'b0}, '{ACT_BYTE, 8'h01, 1'b0},
    '{ACT_BYTE, 8'h84, 1'b0}, '{ACT_BYTE, 8'h0A, 1'b0},
    '{ACT_FETCH, 8'h00, 1'b0}, '{ACT_FETCH, 8'h00, 1'b0}, '{ACT_FETCH, 8'h00, 1'b0},
    '{ACT_FETCH, 8'h00, 1'b0}, '{ACT_FETCH, 8'h00, 1'b0}, '{ACT_FETCH, 8'h00, 1'b0},
    '{ACT_FETCH, 8'h00, 1'b0}, '{ACT_FETCH, 8'h00, 1'b0}, '{ACT_POLL, 8'h00, 1'b0},
    '{ACT_BYTE, 8'h01, 1'b0}, '{ACT_BYTE, 8'h06, 1'b0}, '{ACT_BYTE, 8'h00, 1'b0},
    '{ACT_BYTE, 8'h01, 1'b0}, '{ACT_BYTE, 8'h00, 1'b0}, '{ACT_BYTE, 8'h03, 1'b0},
    '{ACT_BYTE, 8'h98, 1'b0}, '{ACT_BYTE, 8'h0B, 1'b0}, '{ACT_FETCH, 8'h00, 1'b0}
  };

  initial begin
    int over_base;
    for (int i = 0; i < REG_COUNT; i++) bank[i] = 16'h0000;
    for (int i = 0; i < ST_NUM; i++) stats[i] = 16'h0000;
    rx_n = 0; tx_len = 0; tx_pos = 0; quiet_ticks = 0; last_n = 0;
    my_addr = 1; my_silence = 4;
    errors = 0; items = 0; n_frames_sent = 0; n_fetched = 0;
    quiet = 1'b0; hold_req = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) put_item(dir_rows[i].act, dir_rows[i].data, dir_rows[i].typed);

    // defaults written back explicitly, then buffer overflow with a head that never frames
    write_reg(CFG_SLAVE_ADDR, 1);
    write_reg(CFG_SILENCE, 4);
    over_base = items;
    put_item(ACT_BYTE, 8'(my_addr));
    while (items - over_base < RX_DEPTH + 1) put_item(ACT_BYTE, 8'h41);
    repeat (3) put_item(ACT_TICK, 8'h00);
    run_phase(250);

    // extremes: top address, shortest silence, long receiver hold-off mid phase
    write_reg(CFG_SLAVE_ADDR, 247);
    write_reg(CFG_SILENCE, 1);
    run_phase(380);
    hold_req = 1'b1;
    run_phase(480);

    // silence never expires, sender pauses until the slave has drained
    write_reg(CFG_SLAVE_ADDR, $urandom_range(1, 247));
    write_reg(CFG_SILENCE, 65535);
    run_phase(580);
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    run_phase(650);

    // random settings, last stretch without any idling
    write_reg(CFG_SLAVE_ADDR, $urandom_range(1, 247));
    write_reg(CFG_SILENCE, $urandom_range(1, 8));
    run_phase(780);
    quiet = 1'b1;
    run_phase(900);

    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("covered %0d transactions, %0d requests, %0d response bytes fetched",
             items, n_frames_sent, n_fetched);
    $display("counters: %0d frames ok, %0d crc errors, %0d exceptions",
             stats[ST_FRAMES], stats[ST_CRC], stats[ST_EXC]);
    if (errors == 0) begin
      $display("tb_modbus_rtu_slave_framer_top: clean");
    end else begin
      $display("tb_modbus_rtu_slave_framer_top: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("tb_modbus_rtu_slave_framer_top: errors");
    $finish;
  end

endmodule

`default_nettype wire
